@@ src/spjs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the slack priority job scheduler
package spjs_pkg;

  localparam int QDEPTH = 32;
  localparam int AW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam int IW     = 16;
  localparam int TW     = 32;
  localparam int KW     = TW + 1;

  typedef struct packed {
    logic [TW-1:0] arrival_time;
    logic [TW-1:0] deadline;
    logic          is_last;
  } job_req_t;

  typedef struct packed {
    logic [IW-1:0] job_index;
    logic [TW-1:0] start_time;
    logic          dropped;
    logic          last_of_run;
  } job_res_t;

  // one waiting job: signed slack key and running index
  typedef struct packed {
    logic [KW-1:0] key;
    logic [IW-1:0] idx;
  } entry_t;

  // scan control from the sequencer to the selection unit
  typedef struct packed {
    logic          vld;
    logic          first;
    logic [AW-1:0] pos;
  } sel_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SCAN,
    ST_WB,
    ST_STORE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

@@ src/slack_priority_job_scheduler_unit.sv @@
`timescale 1ns / 1ps
// top level: sequencer, queue state and result path of the job scheduler
//
// A job request (arrival time, deadline, last flag) is taken at a clock edge
// where start is high and busy is low. Each job gets a running index and a
// slack key of deadline minus arrival. Before the job is queued, waiting jobs
// are started one per time unit while the arrival lies later than the current
// time; each start picks the largest slack, ties to the larger index. A job
// that finds all 32 slots taken is reported as dropped. A request flagged as
// last drains the whole queue and then returns time and index to zero.
// Results appear on res_o for exactly one cycle with res_valid_o high; the
// final result of a request carries last_of_run. The receiver cannot stall.
// The queue memory is scanned one read a cycle through one shared compare unit,
// so each started job takes longer the more jobs are waiting; busy stays high
// until the request is done, and a new request is taken only after that. A
// result is held until the next one is made or the request ends, and appears
// in the cycle after that. Reset empties the queue and clears time and index;
// the memory contents need no clearing.
module slack_priority_job_scheduler_unit
  import spjs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  job_req_t req_i,
  output logic     res_valid_o,
  output job_res_t res_o
);

  state_e        state_q, state_d;
  job_req_t      req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] cur_time_q, cur_time_d;
  logic [IW-1:0] next_idx_q, next_idx_d;
  logic          drain_q, drain_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          rd_vld_q;
  logic [AW-1:0] rd_pos_q;
  logic          pend_vld_q, pend_vld_d;
  job_res_t      pend_q, pend_d;
  logic          out_vld_q, out_vld_d;
  job_res_t      out_q, out_d;

  logic          rd_en;
  logic          scan_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  sel_ctrl_t     sel_ctrl;
  logic [AW-1:0] best_pos;
  logic [IW-1:0] best_idx;
  logic          emit;
  job_res_t      emit_res;
  logic [KW-1:0] new_key;

  // queue memory and compare unit
  spjs_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign sel_ctrl.vld   = rd_vld_q;
  assign sel_ctrl.first = (rd_pos_q == '0);
  assign sel_ctrl.pos   = rd_pos_q;

  spjs_sel u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .data_i     (rd_data),
    .best_pos_o (best_pos),
    .best_idx_o (best_idx)
  );

  // scan issue and completion
  assign rd_en     = (state_q == ST_SCAN) && (scan_q < count_q);
  assign scan_done = rd_vld_q && (CW'(rd_pos_q) == count_q - CW'(1));
  assign new_key   = {1'b0, req_q.deadline} - {1'b0, req_q.arrival_time};

  // sequencer: next state, queue state and result generation
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    count_d    = count_q;
    cur_time_d = cur_time_q;
    next_idx_d = next_idx_q;
    drain_d    = drain_q;
    scan_d     = scan_q;
    wr_en      = 1'b0;
    wr_addr    = best_pos;
    wr_data    = rd_data;
    emit       = 1'b0;
    emit_res   = '0;
    out_vld_d  = 1'b0;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          drain_d = 1'b0;
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        if ((count_q != '0) && (req_q.arrival_time > cur_time_q)) begin
          scan_d  = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_d = scan_q + CW'(1);
        end
        if (scan_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        // move the last entry into the freed slot and start the best job
        wr_en              = 1'b1;
        emit               = 1'b1;
        emit_res.job_index  = best_idx;
        emit_res.start_time = cur_time_q;
        cur_time_d         = cur_time_q + TW'(1);
        count_d            = count_q - CW'(1);
        state_d            = drain_q ? ST_DRAIN : ST_PRE;
      end
      ST_STORE: begin
        cur_time_d = req_q.arrival_time;
        next_idx_d = next_idx_q + IW'(1);
        if (count_q == CW'(QDEPTH)) begin
          emit               = 1'b1;
          emit_res.job_index = next_idx_q;
          emit_res.dropped   = 1'b1;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = count_q[AW-1:0];
          wr_data.key  = new_key;
          wr_data.idx  = next_idx_q;
          count_d      = count_q + CW'(1);
        end
        if (req_q.is_last) begin
          drain_d = 1'b1;
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DRAIN: begin
        if (count_q != '0) begin
          scan_d  = '0;
          state_d = ST_SCAN;
        end else begin
          cur_time_d = '0;
          next_idx_d = '0;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // the held result is the last one of this request
        if (pend_vld_q) begin
          out_vld_d         = 1'b1;
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          pend_vld_d        = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hold each new result until the next one shows it was not the last
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = pend_q;
      end
      pend_vld_d = 1'b1;
      pend_d     = emit_res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      cur_time_q <= '0;
      next_idx_q <= '0;
      drain_q    <= 1'b0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_pos_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cur_time_q <= cur_time_d;
      next_idx_q <= next_idx_d;
      drain_q    <= drain_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_en;
      rd_pos_q   <= scan_q[AW-1:0];
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // a taken request keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // results only follow work done while busy
  a_res_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result while idle");

  // queue fill never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QDEPTH))
    else $error("queue count out of range");

  // a dropped job never carries a start time
  a_drop_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.dropped |-> res_o.start_time == '0)
    else $error("dropped job with start time");

  // nothing is held over once the block is idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_vld_q)
    else $error("pending result while idle");

endmodule

@@ src/spjs_mem.sv @@
`timescale 1ns / 1ps
// waiting-job memory: one write port, one registered read port
module spjs_mem
  import spjs_pkg::*;
(
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [QDEPTH];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, holds its value when idle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/spjs_sel.sv @@
`timescale 1ns / 1ps
// shared compare unit: keeps the best entry seen during a scan
module spjs_sel
  import spjs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sel_ctrl_t     ctrl_i,
  input  entry_t        data_i,
  output logic [AW-1:0] best_pos_o,
  output logic [IW-1:0] best_idx_o
);

  logic [KW-1:0] best_key_q, best_key_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [AW-1:0] best_pos_q, best_pos_d;
  logic          key_gt, key_eq, take;

  // larger slack wins, ties go to the larger index
  always_comb begin
    key_gt     = $signed(data_i.key) > $signed(best_key_q);
    key_eq     = data_i.key == best_key_q;
    take       = ctrl_i.vld && (ctrl_i.first || key_gt || (key_eq && data_i.idx > best_idx_q));
    best_key_d = take ? data_i.key : best_key_q;
    best_idx_d = take ? data_i.idx : best_idx_q;
    best_pos_d = take ? ctrl_i.pos : best_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_pos_q <= '0;
    end else begin
      best_pos_q <= best_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
  end

  assign best_pos_o = best_pos_q;
  assign best_idx_o = best_idx_q;

endmodule

@@ test/tb_slack_priority_job_scheduler_unit.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the slack priority job scheduler: directed table and random runs
module tb_slack_priority_job_scheduler_unit;
  import spjs_pkg::*;

  localparam int RANDOM_JOBS = 200;

  // one directed request, repeated rep times; res is typed in only where obvious
  typedef struct {
    logic [TW-1:0] arr;
    logic [TW-1:0] dl;
    logic          last;
    int            rep;
    bit            typed;
    job_res_t      res;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  job_req_t req_i;
  logic     res_valid_o;
  job_res_t res_o;

  // scheduler mirror: waiting slots, current time, running index
  logic signed [KW-1:0] slot_key [QDEPTH];
  logic [IW-1:0]        slot_idx [QDEPTH];
  int                   slot_cnt;
  logic [TW-1:0]        now_t;
  logic [IW-1:0]        idx_ctr;

  job_res_t job_outcomes[$];
  job_res_t pending_starts[$];
  dir_row_t dir_rows[$];
  int       err_cnt;

  slack_priority_job_scheduler_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #64_000_000;
    $display("Verification failed");
    $finish;
  end

  // start the waiting job with the largest slack, ties to the larger index
  task automatic start_best();
    int       best;
    job_res_t res;
    best = 0;
    for (int i = 1; i < slot_cnt; i++) begin
      if (slot_key[i] > slot_key[best] ||
          (slot_key[i] == slot_key[best] && slot_idx[i] > slot_idx[best])) begin
        best = i;
      end
    end
    res = '{job_index: slot_idx[best], start_time: now_t,
            dropped: 1'b0, last_of_run: 1'b0};
    job_outcomes = {job_outcomes, res};
    now_t    = now_t + TW'(1);
    slot_cnt = slot_cnt - 1;
    slot_key[best] = slot_key[slot_cnt];
    slot_idx[best] = slot_idx[slot_cnt];
  endtask

  // results that one accepted request causes, left in job_outcomes
  task automatic schedule_job(input job_req_t r);
    logic signed [KW-1:0] slack;
    job_res_t             drop_res;
    job_outcomes.delete();
    while (slot_cnt > 0 && r.arrival_time > now_t) start_best();
    now_t = r.arrival_time;
    slack = $signed({1'b0, r.deadline}) - $signed({1'b0, r.arrival_time});
    if (slot_cnt >= QDEPTH) begin
      drop_res = '{job_index: idx_ctr, start_time: '0,
                   dropped: 1'b1, last_of_run: 1'b0};
      job_outcomes = {job_outcomes, drop_res};
    end else begin
      slot_key[slot_cnt] = slack;
      slot_idx[slot_cnt] = idx_ctr;
      slot_cnt = slot_cnt + 1;
    end
    idx_ctr = idx_ctr + IW'(1);
    if (r.is_last) begin
      while (slot_cnt > 0) start_best();
      now_t   = '0;
      idx_ctr = '0;
    end
    if (job_outcomes.size() > 0) job_outcomes[$].last_of_run = 1'b1;
  endtask

  // present one request and hold it until taken
  task automatic send_job(input job_req_t r, input bit typed, input job_res_t typed_res);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    schedule_job(r);
    if (typed) begin
      pending_starts = {pending_starts, typed_res};
    end else begin
      pending_starts = {pending_starts, job_outcomes};
    end
  endtask

  // drop start for a while, with junk on the request bus
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      req_i <= {$urandom, $urandom, 1'($urandom)};
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold off until every expected start has come out
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_starts.size() != 0);
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dir_row_t mk_row(input logic [TW-1:0] arr, input logic [TW-1:0] dl,
                                      input logic last, input int rep, input bit typed,
                                      input logic [IW-1:0] idx, input logic [TW-1:0] st,
                                      input logic drop);
    dir_row_t row;
    row.arr   = arr;
    row.dl    = dl;
    row.last  = last;
    row.rep   = rep;
    row.typed = typed;
    row.res   = '{job_index: idx, start_time: st, dropped: drop, last_of_run: 1'b1};
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin : chk_res
    job_res_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (pending_starts.size() == 0) begin
        report("unexpected result", 64'h0, 64'(res_o));
      end else begin
        want = pending_starts.pop_front();
        if (res_o.job_index !== want.job_index)
          report("job_index", 64'(want.job_index), 64'(res_o.job_index));
        if (res_o.start_time !== want.start_time)
          report("start_time", 64'(want.start_time), 64'(res_o.start_time));
        if (res_o.dropped !== want.dropped)
          report("dropped", 64'(want.dropped), 64'(res_o.dropped));
        if (res_o.last_of_run !== want.last_of_run)
          report("last_of_run", 64'(want.last_of_run), 64'(res_o.last_of_run));
      end
    end
  end

  // stimulus
  initial begin : stim
    job_req_t      rq;
    job_res_t      no_res;
    logic [TW-1:0] arr;
    logic [TW:0]   sum;
    int            run_len;
    int            n_rand_jobs;
    int            sel;
    bit            burst;
    bit            quiet;

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    no_res      = '0;
    err_cnt     = 0;
    slot_cnt    = 0;
    now_t       = '0;
    idx_ctr     = '0;
    n_rand_jobs = 0;

    // single jobs from an empty queue, both time extremes
    add_row(mk_row(32'h0, 32'h0, 1'b1, 1, 1'b1, 16'd0, 32'h0, 1'b0));
    add_row(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b1, 16'd0,
                   32'hFFFF_FFFF, 1'b0));
    // slack extremes and an index tie, served by a far later arrival
    add_row(mk_row(32'h0, 32'h0, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'h0, 32'hFFFF_FFFF, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'h0, 32'h0, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'hFFFF_FFFF, 32'h0, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    // arrival earlier than current time, then drain
    add_row(mk_row(32'd3, 32'd7, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'd3, 32'd3, 1'b1, 1, 1'b0, '0, '0, 1'b0));
    // start time wraps past the top during the drain
    add_row(mk_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'hFFFF_FFFE, 32'hFFFF_FFF0, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'hFFFF_FFFF, 32'h0, 1'b1, 1, 1'b0, '0, '0, 1'b0));
    // fill all slots at one time, then a dropped job, then drop plus full drain
    add_row(mk_row(32'd10, 32'd20, 1'b0, QDEPTH, 1'b0, '0, '0, 1'b0));
    add_row(mk_row(32'd10, 32'd0, 1'b0, 1, 1'b1, 16'(QDEPTH), 32'h0, 1'b1));
    add_row(mk_row(32'd10, 32'd0, 1'b1, 1, 1'b0, '0, '0, 1'b0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].rep; k++) begin
        rq.arrival_time = dir_rows[i].arr;
        rq.deadline     = dir_rows[i].dl;
        rq.is_last      = dir_rows[i].last;
        send_job(rq, dir_rows[i].typed, dir_rows[i].res);
        idle_for(pick_gap());
      end
    end
    hold_until_drained();

    // random runs of mostly nondecreasing arrivals, each closed by a last job
    while (n_rand_jobs < RANDOM_JOBS) begin
      run_len = $urandom_range(1, 45);
      burst   = ($urandom_range(0, 4) == 0);
      quiet   = ($urandom_range(0, 3) == 0);
      sel     = $urandom_range(0, 3);
      if (sel == 0) arr = '0;
      else if (sel == 1) arr = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else arr = $urandom;
      for (int k = 0; k < run_len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          arr = $urandom;
        end else begin
          if (sel < 12) sum = {1'b0, arr} + (TW+1)'($urandom_range(1, 1000));
          else if (burst) sum = {1'b0, arr};
          else sum = {1'b0, arr} + (TW+1)'($urandom_range(0, 2));
          arr = sum[TW] ? 32'hFFFF_FFFF : sum[TW-1:0];
        end
        rq.arrival_time = arr;
        if ($urandom_range(0, 9) < 3) rq.deadline = $urandom;
        else rq.deadline = arr + 32'($urandom_range(0, 60)) - 32'd30;
        rq.is_last = (k == run_len - 1);
        send_job(rq, 1'b0, no_res);
        n_rand_jobs++;
        if (!quiet) idle_for(pick_gap());
      end
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    // wait for the tail, then a little longer for stray results
    start <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
